>>> src/adag_pkg.sv
// Shared types and constants for the array descriptor address generator.
// No dependencies; used by every module of the block but adag_fifo.
`default_nettype none
package adag_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_BOUND  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam int IdW   = 4;
  localparam int BaseW = 31;
  localparam int SizeW = 16;
  localparam int DimW  = 4;
  localparam int ValW  = 16;
  localparam int AddrW = 32;

  // Classified item passed from front to back
  typedef struct packed {
    logic [1:0]              op;
    logic [IdW-1:0]          id;
    logic [BaseW-1:0]        base;
    logic [SizeW-1:0]        size;
    logic [DimW-1:0]         cnt;
    logic signed [ValW-1:0]  lower;
    logic signed [ValW-1:0]  upper;
    logic signed [ValW-1:0]  subscript;
  } item_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [AddrW-1:0] addr;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_QMUL,
    ST_QACC,
    ST_FIN_RD,
    ST_FIN_INIT,
    ST_FIN_MUL,
    ST_FIN_ACC
  } state_e;

endpackage
`default_nettype wire

>>> src/adag_fifo.sv
// Two-entry register queue used between the block's parts.
// No package dependency.
`default_nettype none
module adag_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop)      count_q <= count_q + 2'd1;
      else if (do_pop && !do_push) count_q <= count_q - 2'd1;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule
`default_nettype wire

>>> src/adag_front.sv
// Front part: accepts input items, drops meaningless ones, saturates the
// dimension count and queues the rest. Depends on adag_pkg and adag_fifo.
`default_nettype none
module adag_front #(
  parameter int MAX_ARRAYS = 16,
  parameter int MAX_DIMS   = 10
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push_i,
  output logic                                  full_o,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [adag_pkg::IdW-1:0]         array_id_i,
  input  wire logic [adag_pkg::BaseW-1:0]       base_address_i,
  input  wire logic [adag_pkg::SizeW-1:0]       element_size_i,
  input  wire logic [adag_pkg::DimW-1:0]        dimension_count_i,
  input  wire logic signed [adag_pkg::ValW-1:0] lower_bound_i,
  input  wire logic signed [adag_pkg::ValW-1:0] upper_bound_i,
  input  wire logic signed [adag_pkg::ValW-1:0] subscript_i,
  input  wire logic                             item_pop_i,
  output adag_pkg::item_t                       item_o,
  output logic                                  item_empty_o
);

  adag_pkg::item_t item;
  logic            keep;

  // Classify: saturate the dimension count, drop unknown operations and out-of-range arrays
  always_comb begin
    item.op        = operation_i;
    item.id        = array_id_i;
    item.base      = base_address_i;
    item.size      = element_size_i;
    item.cnt       = (32'(dimension_count_i) > MAX_DIMS) ?
                     adag_pkg::DimW'(MAX_DIMS) : dimension_count_i;
    item.lower     = lower_bound_i;
    item.upper     = upper_bound_i;
    item.subscript = subscript_i;
    keep = (32'(array_id_i) < MAX_ARRAYS) &&
           (operation_i == adag_pkg::OP_HEADER || operation_i == adag_pkg::OP_BOUND ||
            operation_i == adag_pkg::OP_QUERY);
  end

  adag_fifo #(.WIDTH($bits(adag_pkg::item_t))) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i && keep),
    .data_i  (item),
    .full_o  (full_o),
    .pop_i   (item_pop_i),
    .data_o  (item_o),
    .empty_o (item_empty_o)
  );

endmodule
`default_nettype wire

>>> src/adag_back.sv
// Back part: descriptor memories, stride/offset walk and subscript
// multiply-accumulate. Depends on adag_pkg.
`default_nettype none
module adag_back #(
  parameter int MAX_ARRAYS = 16,
  parameter int MAX_DIMS   = 10
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire adag_pkg::item_t           item_i,
  input  wire logic                      item_empty_i,
  output logic                           item_pop_o,
  output logic                           res_push_o,
  output adag_pkg::result_t              res_o,
  input  wire logic                      res_full_i
);

  localparam int Slots = MAX_ARRAYS * MAX_DIMS;
  localparam int ArrW  = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
  localparam int SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int DimW  = adag_pkg::DimW;
  localparam int ValW  = adag_pkg::ValW;
  localparam int AddrW = adag_pkg::AddrW;

  function automatic logic [SlotW-1:0] slot_of(input logic [ArrW-1:0] a,
                                               input logic [DimW-1:0] p);
    slot_of = SlotW'(32'(a) * MAX_DIMS + 32'(p));
  endfunction

  // Memories
  logic [DimW-1:0]          dims_mem   [MAX_ARRAYS];
  logic [adag_pkg::BaseW-1:0] base_mem [MAX_ARRAYS];
  logic [adag_pkg::SizeW-1:0] size_mem [MAX_ARRAYS];
  logic [AddrW-1:0]         offset_mem [MAX_ARRAYS];
  logic [ValW-1:0]          lower_mem  [Slots];
  logic [ValW-1:0]          upper_mem  [Slots];
  logic [AddrW-1:0]         stride_mem [Slots];
  logic [MAX_ARRAYS-1:0]    dval_q;

  adag_pkg::state_e state_q, state_d;
  adag_pkg::item_t  it_q;
  logic [DimW-1:0]  dims_rd_q, dptr_q, qptr_q, p_q, j_q;
  logic             dval_rd_q, qlast_q;
  logic [AddrW-1:0] acc_q, prod_q, stride_rd_q, off_rd_q;
  logic [adag_pkg::BaseW-1:0] base_rd_q;
  logic [adag_pkg::SizeW-1:0] size_rd_q;
  logic [ValW-1:0]  low_rd_q, up_rd_q;
  logic [AddrW-1:0] strd_q, offacc_q, lprod_q, sprod_q;

  logic [ArrW-1:0]  arr, in_arr;
  logic [DimW-1:0]  d, pd, pq;
  logic             blast, qlast;
  logic [AddrW-1:0] qsum, low_x, ext_x, off_new;

  // Decode helpers
  always_comb begin
    arr    = ArrW'(it_q.id);
    in_arr = ArrW'(item_i.id);
    d      = dval_rd_q ? dims_rd_q : '0;
    pd     = (dptr_q >= d) ? '0 : dptr_q;
    pq     = (qptr_q >= d) ? '0 : qptr_q;
    blast  = ({1'b0, pd} + 5'd1) >= {1'b0, d};
    qlast  = ({1'b0, pq} + 5'd1) >= {1'b0, d};
    qsum   = ((p_q == '0) ? off_rd_q : acc_q) + prod_q;
    low_x  = {{(AddrW-ValW){low_rd_q[ValW-1]}}, low_rd_q};
    ext_x  = {{(AddrW-ValW){up_rd_q[ValW-1]}}, up_rd_q} - low_x + 32'd1;
    off_new = offacc_q - lprod_q;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      adag_pkg::ST_IDLE:     if (!item_empty_i) state_d = adag_pkg::ST_DECODE;
      adag_pkg::ST_DECODE: begin
        priority case (it_q.op)
          adag_pkg::OP_BOUND:
            state_d = (d != '0 && blast) ? adag_pkg::ST_FIN_RD : adag_pkg::ST_IDLE;
          adag_pkg::OP_QUERY:
            state_d = (d != '0) ? adag_pkg::ST_QMUL : adag_pkg::ST_IDLE;
          default: state_d = adag_pkg::ST_IDLE;
        endcase
      end
      adag_pkg::ST_QMUL:     state_d = adag_pkg::ST_QACC;
      adag_pkg::ST_QACC:     if (!(qlast_q && res_full_i)) state_d = adag_pkg::ST_IDLE;
      adag_pkg::ST_FIN_RD:   state_d = adag_pkg::ST_FIN_INIT;
      adag_pkg::ST_FIN_INIT: state_d = adag_pkg::ST_FIN_MUL;
      adag_pkg::ST_FIN_MUL:  state_d = adag_pkg::ST_FIN_ACC;
      adag_pkg::ST_FIN_ACC:
        state_d = (j_q == '0) ? adag_pkg::ST_IDLE : adag_pkg::ST_FIN_MUL;
      default:               state_d = adag_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    item_pop_o = (state_q == adag_pkg::ST_IDLE) && !item_empty_i;
    res_push_o = (state_q == adag_pkg::ST_QACC) && qlast_q && !res_full_i;
    res_o.id   = it_q.id;
    res_o.addr = qsum;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= adag_pkg::ST_IDLE;
      dval_q  <= '0;
      dptr_q  <= '0;
      qptr_q  <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == adag_pkg::ST_DECODE) begin
        if (it_q.op == adag_pkg::OP_HEADER) begin
          dval_q[arr] <= 1'b1;
          dptr_q      <= '0;
        end else if (it_q.op == adag_pkg::OP_BOUND && d != '0) begin
          dptr_q <= blast ? '0 : pd + 4'd1;
        end
      end
      if (state_q == adag_pkg::ST_QACC && !(qlast_q && res_full_i)) begin
        acc_q  <= qsum;
        qptr_q <= qlast_q ? '0 : p_q + 4'd1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      it_q      <= item_i;
      dims_rd_q <= dims_mem[in_arr];
      dval_rd_q <= dval_q[in_arr];
    end
    unique case (state_q)
      adag_pkg::ST_DECODE: begin
        if (it_q.op == adag_pkg::OP_HEADER) begin
          dims_mem[arr] <= it_q.cnt;
          base_mem[arr] <= it_q.base;
          size_mem[arr] <= it_q.size;
        end else if (it_q.op == adag_pkg::OP_BOUND) begin
          if (d != '0) begin
            lower_mem[slot_of(arr, pd)] <= it_q.lower;
            upper_mem[slot_of(arr, pd)] <= it_q.upper;
            j_q <= pd;
          end
        end else begin
          p_q         <= pq;
          qlast_q     <= qlast;
          stride_rd_q <= stride_mem[slot_of(arr, pq)];
          off_rd_q    <= offset_mem[arr];
        end
      end
      adag_pkg::ST_QMUL:
        prod_q <= 32'({{(AddrW-ValW){it_q.subscript[ValW-1]}}, it_q.subscript} * stride_rd_q);
      adag_pkg::ST_FIN_RD: begin
        base_rd_q <= base_mem[arr];
        size_rd_q <= size_mem[arr];
        low_rd_q  <= lower_mem[slot_of(arr, j_q)];
        up_rd_q   <= upper_mem[slot_of(arr, j_q)];
      end
      adag_pkg::ST_FIN_INIT: begin
        strd_q   <= {{(AddrW-adag_pkg::SizeW){1'b0}}, size_rd_q};
        offacc_q <= {1'b0, base_rd_q};
      end
      adag_pkg::ST_FIN_MUL: begin
        stride_mem[slot_of(arr, j_q)] <= strd_q;
        lprod_q <= 32'(low_x * strd_q);
        sprod_q <= 32'(strd_q * ext_x);
        if (j_q != '0) begin
          low_rd_q <= lower_mem[slot_of(arr, j_q - 4'd1)];
          up_rd_q  <= upper_mem[slot_of(arr, j_q - 4'd1)];
        end
      end
      adag_pkg::ST_FIN_ACC: begin
        offacc_q <= off_new;
        strd_q   <= sprod_q;
        if (j_q == '0) offset_mem[arr] <= off_new;
        else           j_q <= j_q - 4'd1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> src/array_descriptor_address_generator_top.sv
// Top level of the array descriptor address generator.
// Depends on adag_pkg, adag_front, adag_back and adag_fifo.
`default_nettype none
// Keeps up to MAX_ARRAYS row-major array descriptors. A header item (op 0)
// sets base, element size and dimension count; bound items (op 1) give each
// dimension's bounds in order, and the last one starts a backward walk that
// computes strides and the constant offset, dimension by dimension, through
// one shared pair of multipliers. Subscript items (op 2) are multiply-added one
// per item; after the final subscript the address appears on the result queue.
// Items pass through a two-entry input queue; in the back end a query subscript
// passes IDLE, DECODE, QMUL and QACC, a header or a non-final bound IDLE and
// DECODE, a final bound also FIN_RD, FIN_INIT and FIN_MUL, FIN_ACC per dimension.
// Results wait in a two-entry output queue; a final subscript stalls while it is full.
module array_descriptor_address_generator_top #(
  parameter int MAX_ARRAYS = 16,
  parameter int MAX_DIMS   = 10
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [adag_pkg::IdW-1:0]         array_id_i,
  input  wire logic [adag_pkg::BaseW-1:0]       base_address_i,
  input  wire logic [adag_pkg::SizeW-1:0]       element_size_i,
  input  wire logic [adag_pkg::DimW-1:0]        dimension_count_i,
  input  wire logic signed [adag_pkg::ValW-1:0] lower_bound_i,
  input  wire logic signed [adag_pkg::ValW-1:0] upper_bound_i,
  input  wire logic signed [adag_pkg::ValW-1:0] subscript_i,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic [adag_pkg::IdW-1:0]              result_array_o,
  output logic signed [adag_pkg::AddrW-1:0]     address_o
);

  adag_pkg::item_t   item;
  logic              item_empty, item_pop;
  adag_pkg::result_t res, res_out;
  logic              res_push, res_full;

  adag_front #(.MAX_ARRAYS(MAX_ARRAYS), .MAX_DIMS(MAX_DIMS)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_o            (full),
    .operation_i       (operation_i),
    .array_id_i        (array_id_i),
    .base_address_i    (base_address_i),
    .element_size_i    (element_size_i),
    .dimension_count_i (dimension_count_i),
    .lower_bound_i     (lower_bound_i),
    .upper_bound_i     (upper_bound_i),
    .subscript_i       (subscript_i),
    .item_pop_i        (item_pop),
    .item_o            (item),
    .item_empty_o      (item_empty)
  );

  adag_back #(.MAX_ARRAYS(MAX_ARRAYS), .MAX_DIMS(MAX_DIMS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_empty_i (item_empty),
    .item_pop_o   (item_pop),
    .res_push_o   (res_push),
    .res_o        (res),
    .res_full_i   (res_full)
  );

  // Hold finished results for the consumer
  adag_fifo #(.WIDTH($bits(adag_pkg::result_t))) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign result_array_o = res_out.id;
  assign address_o      = res_out.addr;

endmodule
`default_nettype wire

>>> dv/adag_checker.sv
// Address checker for the array descriptor address generator: watches both
// queue ports, predicts element addresses and compares them. Depends on adag_pkg.
module adag_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  input  logic                                  full_i,
  input  logic [1:0]                            operation_i,
  input  logic [adag_pkg::IdW-1:0]              array_id_i,
  input  logic [adag_pkg::BaseW-1:0]            base_address_i,
  input  logic [adag_pkg::SizeW-1:0]            element_size_i,
  input  logic [adag_pkg::DimW-1:0]             dimension_count_i,
  input  logic signed [adag_pkg::ValW-1:0]      lower_bound_i,
  input  logic signed [adag_pkg::ValW-1:0]      upper_bound_i,
  input  logic signed [adag_pkg::ValW-1:0]      subscript_i,
  input  logic                                  empty_i,
  input  logic                                  pop_i,
  input  logic [adag_pkg::IdW-1:0]              result_array_i,
  input  logic signed [adag_pkg::AddrW-1:0]     address_i,
  output int                                    mismatches_o,
  output int                                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NArr = 16;
  localparam int NDim = 10;

  logic [3:0]  dims_q   [NArr];
  logic [31:0] base_q   [NArr];
  logic [31:0] size_q   [NArr];
  logic [31:0] offset_q [NArr];
  logic [31:0] lower_q  [NArr*NDim];
  logic [31:0] upper_q  [NArr*NDim];
  logic [31:0] stride_q [NArr*NDim];
  int unsigned def_ptr, qry_ptr;
  logic [31:0] addr_acc;
  adag_pkg::result_t addr_queue [$];

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatches_o++;
  endtask

  // Walk strides backward from the element size and fold lower bounds into offset
  task automatic finish_definition(int a);
    int j;
    logic [31:0] stride, off;
    j = int'(dims_q[a]) - 1;
    stride = size_q[a];
    off = base_q[a];
    stride_q[a*NDim+j] = stride;
    off -= lower_q[a*NDim+j] * stride;
    while (j > 0) begin
      stride = stride * (upper_q[a*NDim+j] - lower_q[a*NDim+j] + 32'd1);
      j--;
      stride_q[a*NDim+j] = stride;
      off -= lower_q[a*NDim+j] * stride;
    end
    offset_q[a] = off;
  endtask

  // Advance the predicted state by one accepted transaction
  task automatic predict_item();
    int a, d, p;
    logic [3:0] cnt;
    adag_pkg::result_t r;
    a = int'(array_id_i);
    d = int'(dims_q[a]);
    case (operation_i)
      adag_pkg::OP_HEADER: begin
        cnt = dimension_count_i > 4'd10 ? 4'd10 : dimension_count_i;
        base_q[a] = {1'b0, base_address_i};
        size_q[a] = {16'd0, element_size_i};
        dims_q[a] = cnt;
        def_ptr = 0;
      end
      adag_pkg::OP_BOUND: if (d != 0) begin
        p = def_ptr >= d ? 0 : def_ptr;
        lower_q[a*NDim+p] = sext16(lower_bound_i);
        upper_q[a*NDim+p] = sext16(upper_bound_i);
        p++;
        if (p >= d) begin
          finish_definition(a);
          p = 0;
        end
        def_ptr = p;
      end
      adag_pkg::OP_QUERY: if (d != 0) begin
        p = qry_ptr >= d ? 0 : qry_ptr;
        if (p == 0) addr_acc = offset_q[a];
        addr_acc += sext16(subscript_i) * stride_q[a*NDim+p];
        p++;
        if (p >= d) begin
          r.id = array_id_i;
          r.addr = addr_acc;
          addr_queue = {addr_queue, r};
          p = 0;
        end
        qry_ptr = p;
      end
      default: ;
    endcase
  endtask

  initial begin
    mismatches_o = 0;
    for (int i = 0; i < NArr; i++) dims_q[i] = '0;
    def_ptr = 0;
    qry_ptr = 0;
    addr_acc = '0;
  end

  // Predict on input transactions, compare on output transactions
  always @(posedge clk_i) begin
    adag_pkg::result_t want;
    if (rst_ni) begin
      if (pop_i && !empty_i) begin
        if (addr_queue.size() == 0) begin
          report("unexpected address", address_i, '0);
        end else begin
          want = addr_queue.pop_front();
          if (result_array_i !== want.id) report("result_array", 32'(result_array_i), 32'(want.id));
          if (address_i !== want.addr) report("address", address_i, want.addr);
        end
      end
      if (push_i && !full_i) predict_item();
    end
    pending_o <= addr_queue.size();
  end
endmodule

>>> dv/testbench.sv
// Stimulus and verdict for the array descriptor address generator.
// Depends on adag_pkg, array_descriptor_address_generator_top and adag_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NArr = 16;
  localparam int NDim = 10;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0, pop = 1'b0;
  logic full, empty;
  logic [1:0] operation = '0;
  logic [adag_pkg::IdW-1:0] array_id = '0;
  logic [adag_pkg::BaseW-1:0] base_address = '0;
  logic [adag_pkg::SizeW-1:0] element_size = '0;
  logic [adag_pkg::DimW-1:0] dimension_count = '0;
  logic signed [adag_pkg::ValW-1:0] lower_bound = '0, upper_bound = '0, subscript = '0;
  logic [adag_pkg::IdW-1:0] result_array;
  logic signed [adag_pkg::AddrW-1:0] address;
  int mismatches, pending;
  int cycles = 0;
  int sent = 0;
  bit no_idle = 1'b0;

  // Which descriptor entries have been written, to avoid reading undefined ones
  int unsigned dims_sh [NArr];
  bit lower_w [NArr*NDim], upper_w [NArr*NDim], stride_w [NArr*NDim], offset_w [NArr];
  int unsigned def_ptr_sh = 0, qry_ptr_sh = 0;

  always #5 clk = ~clk;

  array_descriptor_address_generator_top DUT (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full),
    .operation_i(operation), .array_id_i(array_id), .base_address_i(base_address),
    .element_size_i(element_size), .dimension_count_i(dimension_count),
    .lower_bound_i(lower_bound), .upper_bound_i(upper_bound), .subscript_i(subscript),
    .empty(empty), .pop(pop), .result_array_o(result_array), .address_o(address)
  );

  adag_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .push_i(push), .full_i(full),
    .operation_i(operation), .array_id_i(array_id), .base_address_i(base_address),
    .element_size_i(element_size), .dimension_count_i(dimension_count),
    .lower_bound_i(lower_bound), .upper_bound_i(upper_bound), .subscript_i(subscript),
    .empty_i(empty), .pop_i(pop), .result_array_i(result_array), .address_i(address),
    .mismatches_o(mismatches), .pending_o(pending)
  );

  // Return whether an item reads only written entries; commit its effect if so
  function automatic bit admit_item(logic [1:0] op, int a, int cnt);
    int unsigned d, p;
    d = dims_sh[a];
    if (op == adag_pkg::OP_HEADER) begin
      dims_sh[a] = cnt > NDim ? NDim : cnt;
      def_ptr_sh = 0;
      return 1'b1;
    end
    if (d == 0) return 1'b1;
    if (op == adag_pkg::OP_BOUND) begin
      p = def_ptr_sh >= d ? 0 : def_ptr_sh;
      if (p + 1 >= d) begin
        for (int j = 0; j < d; j++)
          if (j != p && (!lower_w[a*NDim+j] || (j > 0 && !upper_w[a*NDim+j]))) return 1'b0;
        for (int j = 0; j < d; j++) stride_w[a*NDim+j] = 1'b1;
        offset_w[a] = 1'b1;
        p = 0;
      end else p++;
      lower_w[a*NDim+(p == 0 ? d-1 : p-1)] = 1'b1;
      upper_w[a*NDim+(p == 0 ? d-1 : p-1)] = 1'b1;
      def_ptr_sh = p;
      return 1'b1;
    end
    if (op == adag_pkg::OP_QUERY) begin
      p = qry_ptr_sh >= d ? 0 : qry_ptr_sh;
      if (!offset_w[a] || !stride_w[a*NDim+p]) return 1'b0;
      qry_ptr_sh = p + 1 >= d ? 0 : p + 1;
    end
    return 1'b1;
  endfunction

  // Hold one transaction on the input until it is accepted
  task automatic send(logic [1:0] op, int a, logic [30:0] base, logic [15:0] size,
                      int cnt, logic [15:0] lo, logic [15:0] up, logic [15:0] sub);
    bit f;
    if (!admit_item(op, a, cnt)) return;
    while (!no_idle && $urandom_range(99) < 9) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    operation = op; array_id = a[3:0]; base_address = base; element_size = size;
    dimension_count = cnt[3:0]; lower_bound = lo; upper_bound = up; subscript = sub;
    forever begin
      f = full;
      @(posedge clk);
      @(negedge clk);
      if (!f) break;
    end
    push = 1'b0;
    sent++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
  endtask

  // Header followed by every bound of the array, in order
  task automatic define_array(int a, int cnt, bit wide);
    int lo, ext;
    send(adag_pkg::OP_HEADER, a, 31'($urandom), 16'($urandom_range(65535, 1)), cnt, 0, 0, 0);
    for (int j = 0; j < (cnt > NDim ? NDim : cnt); j++) begin
      lo = $urandom_range(65535) - 32768;
      ext = wide ? $urandom_range(65535) : $urandom_range(7);
      send(adag_pkg::OP_BOUND, a, 31'($urandom), 16'($urandom), 0, 16'(lo), 16'(lo + ext), 0);
    end
  endtask

  task automatic query_array(int a);
    for (int j = 0; j < dims_sh[a]; j++)
      send(adag_pkg::OP_QUERY, a, 31'($urandom), 16'($urandom), $urandom_range(15),
           16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Random result consumer, idle with a chance of 9 in 100
  always @(negedge clk) pop <= no_idle || ($urandom_range(99) >= 9);

  // Guard against a hung block
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int a, r;
    for (int i = 0; i < NArr; i++) begin
      dims_sh[i] = 0;
      offset_w[i] = 1'b0;
    end
    for (int i = 0; i < NArr*NDim; i++) begin
      lower_w[i] = 1'b0; upper_w[i] = 1'b0; stride_w[i] = 1'b0;
    end
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: extremes, saturated count, reversed bounds, ignored items
    send(adag_pkg::OP_HEADER, 0, 31'h7FFF_FFFF, 16'hFFFF, 15, 0, 0, 0);
    for (int j = 0; j < NDim; j++)
      send(adag_pkg::OP_BOUND, 0, 0, 0, 0, 16'h8000, 16'h7FFF, 0);
    send(adag_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 16'h7FFF);
    for (int j = 1; j < NDim; j++) send(adag_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 16'h8000);
    send(adag_pkg::OP_HEADER, 1, 31'd0, 16'd1, 2, 0, 0, 0);
    send(adag_pkg::OP_BOUND, 1, 0, 0, 0, 16'd5, 16'hFFFE, 0);
    send(adag_pkg::OP_BOUND, 1, 0, 0, 0, 16'h7FFF, 16'h8000, 0);
    send(adag_pkg::OP_QUERY, 1, 0, 0, 0, 0, 0, 16'd3);
    send(adag_pkg::OP_QUERY, 1, 0, 0, 0, 0, 0, 16'hFFFF);
    send(adag_pkg::OP_HEADER, 2, 31'd100, 16'd4, 0, 0, 0, 0);
    send(adag_pkg::OP_BOUND, 2, 0, 0, 0, 16'd1, 16'd2, 0);
    send(adag_pkg::OP_QUERY, 2, 0, 0, 0, 0, 0, 16'd1);
    send(2'd3, 15, 31'h7FFF_FFFF, 16'hFFFF, 15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    drain();

    // Random: mostly well-formed definitions and queries, some noise
    while (sent < 1450) begin
      no_idle = sent >= 600 && sent < 800;
      r = $urandom_range(99);
      a = $urandom_range(NArr - 1);
      if (r < 15)
        send(2'($urandom), a, 31'($urandom), 16'($urandom), $urandom_range(15),
             16'($urandom), 16'($urandom), 16'($urandom));
      else if (r < 40 || !offset_w[a] || dims_sh[a] == 0)
        define_array(a, $urandom_range(9) == 0 ? $urandom_range(15) : $urandom_range(4, 1),
                     $urandom_range(3) == 0);
      else
        query_array(a);
      if (sent % 300 < 3) drain();
    end
    no_idle = 1'b0;

    drain();
    repeat (100) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end
endmodule
